@@ rtl/core/srle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_pkg - shared types and nibble step logic for the subpicture RLE decoder
// Holds coordinate widths, register map, state and result records, and the
// combinational step that folds one nibble into the run code.
// ----------------------------------------------------------------------------
package srle_pkg;

  localparam int CoordBits   = 12;
  localparam int WideBits    = CoordBits + 1;
  localparam int CfgDataBits = (WideBits > 16) ? WideBits : 16;
  localparam int QueueDepth  = 4;

  typedef enum logic [2:0] {
    RegAreaLeft      = 3'd0,
    RegAreaTop       = 3'd1,
    RegAreaRight     = 3'd2,
    RegColorSelect   = 3'd3,
    RegContrastSel   = 3'd4,
    RegUseColorSel   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CoordBits-1:0] area_left;
    logic [CoordBits-1:0] area_top;
    logic [WideBits-1:0]  area_right;
    logic [15:0]          color_select;
    logic [15:0]          contrast_select;
    logic                 use_color_select;
  } cfg_t;

  // code_accum never exceeds 0x3f while nibbles are held
  typedef struct packed {
    logic [WideBits-1:0] cursor_x;
    logic [WideBits-1:0] cursor_y;
    logic [5:0]          code_accum;
    logic [1:0]          nibbles_held;
    logic                field_select;
  } dec_state_t;

  typedef struct packed {
    logic [CoordBits-1:0] run_x;
    logic [12:0]          run_y;
    logic [12:0]          run_length;
    logic [3:0]           palette_index;
    logic [3:0]           contrast;
    logic                 line_end;
    logic                 next_field;
  } result_t;

  typedef struct packed {
    dec_state_t st;
    logic       emit;
    result_t    res;
  } step_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    slot0;
    result_t    slot1;
  } push_t;

  function automatic step_t nib_step(input dec_state_t s, input cfg_t c, input logic [3:0] nib);
    step_t               r;
    logic [2:0]          held;
    logic [9:0]          code;
    logic [9:0]          limit;
    logic                done;
    logic [WideBits-1:0] room;
    logic [WideBits-1:0] len;
    logic [WideBits-1:0] code_len;
    logic                ends;
    logic [1:0]          color;
    r        = '0;
    held     = {1'b0, s.nibbles_held} + 3'd1;
    code     = {s.code_accum, nib};
    case (s.nibbles_held)
      2'd0:    limit = 10'h004;
      2'd1:    limit = 10'h010;
      2'd2:    limit = 10'h040;
      default: limit = 10'h100;
    endcase
    done     = (code >= limit);
    room     = (s.cursor_x < c.area_right) ? (c.area_right - s.cursor_x) : '0;
    code_len = WideBits'(code[9:2]);
    color    = code[1:0];
    r.st     = s;
    if (!done && held != 3'd4) begin
      r.st.code_accum   = code[5:0];
      r.st.nibbles_held = held[1:0];
    end else begin
      if (done && code_len < room) begin
        len  = code_len;
        ends = 1'b0;
      end else begin
        len  = room;
        ends = 1'b1;
      end
      r.emit                = 1'b1;
      r.res.run_x           = s.cursor_x[CoordBits-1:0];
      r.res.run_y           = 13'(s.cursor_y);
      r.res.run_length      = 13'(len);
      r.res.palette_index   = c.use_color_select ? c.color_select[{color, 2'b00} +: 4]
                                                 : {2'b00, color};
      r.res.contrast        = c.contrast_select[{color, 2'b00} +: 4];
      r.res.line_end        = ends;
      r.st.code_accum       = '0;
      r.st.nibbles_held     = '0;
      if (ends) begin
        r.st.cursor_x     = WideBits'(c.area_left);
        r.st.cursor_y     = s.cursor_y + WideBits'(1);
        r.st.field_select = ~s.field_select;
      end else begin
        r.st.cursor_x     = s.cursor_x + len;
      end
      r.res.next_field      = r.st.field_select;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/srle_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_cfg - configuration register file
// Decodes register index writes into the drawing area and palette selects.
// ----------------------------------------------------------------------------
module srle_cfg
  import srle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.area_left        <= '0;
      cfg.area_top         <= '0;
      cfg.area_right       <= WideBits'(720);
      cfg.color_select     <= 16'h3210;
      cfg.contrast_select  <= 16'h0000;
      cfg.use_color_select <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        RegAreaLeft:    cfg.area_left        <= cfg_data[CoordBits-1:0];
        RegAreaTop:     cfg.area_top         <= cfg_data[CoordBits-1:0];
        RegAreaRight:   cfg.area_right       <= cfg_data[WideBits-1:0];
        RegColorSelect: cfg.color_select     <= cfg_data[15:0];
        RegContrastSel: cfg.contrast_select  <= cfg_data[15:0];
        RegUseColorSel: cfg.use_color_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/srle_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_decode - input register and two-nibble decode step
// Holds one byte, folds both nibbles into the run code and pushes 0..2 runs.
// ----------------------------------------------------------------------------
module srle_decode
  import srle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       queue_room,
  output push_t      push
);

  logic       in_full;
  logic       in_action;
  logic [7:0] in_byte;
  dec_state_t state;
  dec_state_t state_next;
  step_t      step_hi;
  step_t      step_lo;
  logic       fire;

  assign fire     = in_full && queue_room;
  assign in_stall = in_full && !queue_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_action <= action;
      in_byte   <= data_byte;
    end
  end

  always_comb begin
    step_hi    = nib_step(state, cfg, in_byte[7:4]);
    step_lo    = nib_step(step_hi.st, cfg, in_byte[3:0]);
    push       = '0;
    state_next = state;
    if (fire) begin
      if (!in_action) begin
        // new picture: home the cursor, drop partial code
        state_next.cursor_x     = WideBits'(cfg.area_left);
        state_next.cursor_y     = WideBits'(cfg.area_top);
        state_next.code_accum   = '0;
        state_next.nibbles_held = '0;
        state_next.field_select = 1'b0;
      end else if (step_hi.emit && step_hi.res.line_end) begin
        // line ended on high nibble, low nibble dropped
        state_next = step_hi.st;
        push.n     = 2'd1;
        push.slot0 = step_hi.res;
      end else begin
        state_next = step_lo.st;
        if (step_hi.emit) begin
          push.slot0 = step_hi.res;
          push.slot1 = step_lo.res;
          push.n     = step_lo.emit ? 2'd2 : 2'd1;
        end else begin
          push.slot0 = step_lo.res;
          push.n     = step_lo.emit ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !in_stall)
    else $error("stall raised with empty input register");

  a_two_runs_first_open: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> !push.slot0.line_end)
    else $error("second run pushed after a line end");

  a_accum_bound: assert property (@(posedge clk) disable iff (rst)
    (state.nibbles_held == 2'd0 && state.code_accum == 6'd0) ||
    (state.nibbles_held == 2'd1 && state.code_accum < 6'd4) ||
    (state.nibbles_held == 2'd2 && state.code_accum < 6'd16) ||
    (state.nibbles_held == 2'd3))
    else $error("partial code out of range for nibble count");

endmodule

@@ rtl/core/srle_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_queue - result queue
// Four-entry register queue: up to two runs in per cycle, one out if no stall.
// ----------------------------------------------------------------------------
module srle_queue
  import srle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    queue_room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  localparam int PtrBits = $clog2(QueueDepth);

  result_t            mem [QueueDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   count;
  logic               pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign queue_room = (count <= (PtrBits+1)'(QueueDepth - 2));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.slot0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + PtrBits'(1)] <= push.slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrBits'(push.n);
      rd_ptr <= rd_ptr + PtrBits'(pop);
      count  <= count + (PtrBits+1)'(push.n) - (PtrBits+1)'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> count <= (PtrBits+1)'(QueueDepth - 2))
    else $error("push into queue without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count + (PtrBits+1)'(push.n) - (PtrBits+1)'(pop)))
    else $error("queue count lost track of transactions");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PtrBits+1)'(QueueDepth))
    else $error("queue count beyond depth");

endmodule

@@ rtl/core/subpicture_rle_nibble_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpicture_rle_nibble_decoder_top - subpicture run-length decoder
// Turns run-length coded subpicture bytes into runs with position, length,
// palette index and contrast.
// ----------------------------------------------------------------------------
// One input transaction carries either a new-picture command (action 0, which
// homes the cursor to area_left/area_top and clears field and partial code)
// or one data byte (action 1), decoded high nibble first. A byte yields zero,
// one or two run transactions; a line end on the high nibble drops the low
// nibble. An input byte is taken every cycle while the result queue has room
// for two runs, and results leave at one per cycle while out_stall is low, so
// bytes that yield two runs are held back by the single result port. A run
// passes through the input register, then the result queue, before it
// appears. next_field tells the fetch logic which interlaced field supplies
// the next byte. Configuration writes are never stalled (cfg_ready is always
// high) and must be made while no decode is in flight; indexes beyond the
// register map are ignored.
// ----------------------------------------------------------------------------
module subpicture_rle_nibble_decoder_top
  import srle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // config write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data,
  // input byte channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [7:0]             data_byte,
  // run channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CoordBits-1:0]   run_x,
  output logic [12:0]            run_y,
  output logic [12:0]            run_length,
  output logic [3:0]             palette_index,
  output logic [3:0]             contrast,
  output logic                   line_end,
  output logic                   next_field
);

  cfg_t    cfg;
  push_t   push;
  logic    queue_room;
  result_t head;

  // register file
  srle_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // byte register, cursor state and both nibble steps
  srle_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .data_byte  (data_byte),
    .queue_room (queue_room),
    .push       (push)
  );

  // run queue decouples two-run bytes from the single output port
  srle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .queue_room (queue_room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head       (head)
  );

  assign run_x         = head.run_x;
  assign run_y         = head.run_y;
  assign run_length    = head.run_length;
  assign palette_index = head.palette_index;
  assign contrast      = head.contrast;
  assign line_end      = head.line_end;
  assign next_field    = head.next_field;

endmodule

@@ sim/subpicture_rle_nibble_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpicture_rle_nibble_decoder_top_tb - self-checking bench for the RLE decoder
// Feeds byte and new-picture transactions and predicts every run with an
// in-bench nibble decoder. Each run transaction is checked field by field.
// Both channels idle and stall at random across several register settings.
// ----------------------------------------------------------------------------
module subpicture_rle_nibble_decoder_top_tb;
  import srle_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int NumPhases   = 12;
  localparam int PhaseBytes  = 115;    // data bytes per random phase
  localparam int DrainCycles = 8;      // margin after the last predicted run is out
  localparam int MaxPrints   = 40;
  localparam int Predicted   = -1;     // table row checked against the predictor
  localparam int TimeoutNs   = 5_000_000;

  typedef enum logic {
    ActNewPicture = 1'b0,
    ActData       = 1'b1
  } action_e;

  // one row of the directed table; n_typed < 0 means "use the predictor"
  typedef struct {
    action_e     act;
    logic [7:0]  data;
    int          n_typed;
    result_t     run0;
    result_t     run1;
    bit          drain_after;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   action    = 1'b0;
  logic [7:0]             data_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CoordBits-1:0]   run_x;
  logic [12:0]            run_y;
  logic [12:0]            run_length;
  logic [3:0]             palette_index;
  logic [3:0]             contrast;
  logic                   line_end;
  logic                   next_field;

  always #ClkHalf clk = ~clk;

  subpicture_rle_nibble_decoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .run_x         (run_x),
    .run_y         (run_y),
    .run_length    (run_length),
    .palette_index (palette_index),
    .contrast      (contrast),
    .line_end      (line_end),
    .next_field    (next_field)
  );

  // --------------------------------------------------------------------------
  // Predictor: register copies (reset values) and decoder state
  // --------------------------------------------------------------------------
  logic [CoordBits-1:0] left_x   = '0;
  logic [CoordBits-1:0] top_y    = '0;
  logic [WideBits-1:0]  right_x  = 13'd720;
  logic [15:0]          pal_sel  = 16'h3210;
  logic [15:0]          con_sel  = '0;
  logic                 pal_en   = 1'b0;

  logic [WideBits-1:0]  pos_x    = '0;
  logic [WideBits-1:0]  pos_y    = '0;
  logic [15:0]          code_acc = '0;
  logic [1:0]           held_cnt = '0;
  logic                 field_odd = 1'b0;

  result_t    pending_runs[$];   // runs predicted but not yet seen
  result_t    item_runs[$];      // runs caused by the latest byte
  logic [3:0] stream_nibs[$];    // well-formed nibble stream awaiting packing
  dir_row_t   dir_tab[$];

  int mismatch_count = 0;
  bit quiet          = 1'b0;     // no idling on either side while set
  int stall_left     = 0;

  // --------------------------------------------------------------------------
  // Reporting and checking
  // --------------------------------------------------------------------------
  task automatic report_error(input string msg);
    if (mismatch_count < MaxPrints) $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_run();
    result_t want;
    if (pending_runs.size() == 0) begin
      report_error($sformatf("unexpected run x=%0d y=%0d len=%0d",
                             run_x, run_y, run_length));
    end else begin
      want = pending_runs.pop_front();
      check_field("run_x",         run_x,         want.run_x);
      check_field("run_y",         run_y,         want.run_y);
      check_field("run_length",    run_length,    want.run_length);
      check_field("palette_index", palette_index, want.palette_index);
      check_field("contrast",      contrast,      want.contrast);
      check_field("line_end",      line_end,      want.line_end);
      check_field("next_field",    next_field,    want.next_field);
    end
  endtask

  // --------------------------------------------------------------------------
  // Nibble decoder. A code completes once it reaches 4 / 0x10 / 0x40 / 0x100
  // after 1..4 nibbles; four nibbles below 0x100 fill to the right edge.
  // --------------------------------------------------------------------------
  task automatic feed_nibble(input logic [3:0] nib, output bit ended);
    logic [2:0]          n;
    logic [15:0]         code;
    logic [15:0]         lim;
    logic [WideBits-1:0] room;
    logic [WideBits-1:0] len;
    logic [1:0]          col;
    bit                  reached;
    result_t             r;
    n       = {1'b0, held_cnt} + 3'd1;
    code    = {code_acc[11:0], nib};
    lim     = 16'h4 << (2 * (n - 1));
    reached = (code >= lim);
    ended   = 1'b0;
    if (!reached && n != 3'd4) begin
      code_acc = code;
      held_cnt = n[1:0];
    end else begin
      // cursor at or past the edge leaves no room: zero-length run, line ends
      room = (pos_x < right_x) ? right_x - pos_x : '0;
      if (reached && WideBits'(code >> 2) < room) begin
        len   = WideBits'(code >> 2);
        ended = 1'b0;
      end else begin
        len   = room;
        ended = 1'b1;
      end
      col               = code[1:0];
      r.run_x           = pos_x[CoordBits-1:0];
      r.run_y           = 13'(pos_y);
      r.run_length      = 13'(len);
      r.palette_index   = pal_en ? pal_sel[4*col +: 4] : {2'b00, col};
      r.contrast        = con_sel[4*col +: 4];
      r.line_end        = ended;
      code_acc          = '0;
      held_cnt          = '0;
      if (ended) begin
        pos_x     = WideBits'(left_x);
        pos_y     = pos_y + WideBits'(1);    // wraps at WideBits
        field_odd = ~field_odd;
      end else begin
        pos_x     = pos_x + len;
      end
      r.next_field = field_odd;
      item_runs.push_back(r);
    end
  endtask

  // a line end on the high nibble drops the low nibble
  task automatic decode_byte(input action_e act, input logic [7:0] data);
    bit done_line;
    item_runs.delete();
    if (act == ActNewPicture) begin
      pos_x     = WideBits'(left_x);
      pos_y     = WideBits'(top_y);
      code_acc  = '0;
      held_cnt  = '0;
      field_odd = 1'b0;
    end else begin
      feed_nibble(data[7:4], done_line);
      if (!done_line) feed_nibble(data[3:0], done_line);
    end
  endtask

  task automatic queue_item_runs();
    foreach (item_runs[k]) pending_runs.push_back(item_runs[k]);
  endtask

  function automatic result_t mk_run(input int x, input int y, input int len,
                                     input int pal, input int con,
                                     input int le, input int nf);
    result_t r;
    r.run_x         = CoordBits'(x);
    r.run_y         = 13'(y);
    r.run_length    = 13'(len);
    r.palette_index = 4'(pal);
    r.contrast      = 4'(con);
    r.line_end      = 1'(le);
    r.next_field    = 1'(nf);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Well-formed stream: whole run codes of every length, fill codes padded so
  // the next code starts on a byte boundary.
  // --------------------------------------------------------------------------
  function automatic void add_code();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      stream_nibs.push_back(4'($urandom_range(4, 15)));
    end else if (kind < 55) begin
      stream_nibs.push_back(4'($urandom_range(1, 3)));
      stream_nibs.push_back(4'($urandom_range(0, 15)));
    end else if (kind < 75) begin
      stream_nibs.push_back(4'h0);
      stream_nibs.push_back(4'($urandom_range(4, 15)));
      stream_nibs.push_back(4'($urandom_range(0, 15)));
    end else if (kind < 88) begin
      stream_nibs.push_back(4'h0);
      stream_nibs.push_back(4'($urandom_range(1, 3)));
      stream_nibs.push_back(4'($urandom_range(0, 15)));
      stream_nibs.push_back(4'($urandom_range(0, 15)));
    end else begin
      stream_nibs.push_back(4'h0);
      stream_nibs.push_back(4'h0);
      stream_nibs.push_back(4'h0);
      stream_nibs.push_back(4'($urandom_range(0, 3)));
      if (stream_nibs.size() % 2 != 0) stream_nibs.push_back(4'($urandom_range(0, 15)));
    end
  endfunction

  function automatic logic [7:0] next_stream_byte();
    logic [3:0] hi;
    logic [3:0] lo;
    while (stream_nibs.size() < 2) add_code();
    hi = stream_nibs.pop_front();
    lo = stream_nibs.pop_front();
    return {hi, lo};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_stall();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(6, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Drive one transaction and hold it until taken; predict at the accepting edge.
  task automatic accept_item(input action_e act, input logic [7:0] data);
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= data;
    do @(posedge clk); while (in_stall);
    decode_byte(act, data);
  endtask

  task automatic sender_gap();
    int g;
    g = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_stall();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // back-pressure test: sender holds off until every predicted run is out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
  endtask

  // idle point for register writes: queue empty, then cover bytes with no run
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic store_reg(input reg_index_t idx, input logic [CfgDataBits-1:0] v);
    case (idx)
      RegAreaLeft:    left_x  = v[CoordBits-1:0];
      RegAreaTop:     top_y   = v[CoordBits-1:0];
      RegAreaRight:   right_x = v[WideBits-1:0];
      RegColorSelect: pal_sel = v[15:0];
      RegContrastSel: con_sel = v[15:0];
      RegUseColorSel: pal_en  = v[0];
      default: ;
    endcase
  endtask

  // back-to-back writes of the whole register map; valid drops once at the end
  task automatic program_regs(input int left, input int top, input int right,
                              input int csel, input int cns, input int en);
    logic [CfgDataBits-1:0] vals [6];
    reg_index_t             idx;
    vals[RegAreaLeft]    = CfgDataBits'(left);
    vals[RegAreaTop]     = CfgDataBits'(top);
    vals[RegAreaRight]   = CfgDataBits'(right);
    vals[RegColorSelect] = CfgDataBits'(csel);
    vals[RegContrastSel] = CfgDataBits'(cns);
    vals[RegUseColorSel] = CfgDataBits'(en);
    for (int k = 0; k < 6; k++) begin
      idx        = reg_index_t'(k);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      store_reg(idx, vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random phase: new register setting, new picture, then mostly well-formed
  // bytes with some raw bytes and stray new-picture commands mixed in.
  // --------------------------------------------------------------------------
  task automatic run_phase(input int p);
    int          left;
    int          right;
    int          pause_at;
    int          sent;
    int unsigned pick;
    logic [7:0]  b;
    wait_drained();
    if (p == 0) begin
      program_regs(0, 0, 4096, 16'hFFFF, 16'hFFFF, 1);          // widest area, all ones
    end else if (p == 1) begin
      program_regs(4095, 4095, 1, 0, 0, 0);                     // cursor past the edge
    end else if (p == 2) begin
      // edge beyond the coordinate range: cursor runs past 4095
      program_regs(4000, $urandom_range(0, 4095), 8191,
                   $urandom_range(0, 65535), $urandom_range(0, 65535), 1);
    end else begin
      left  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
      right = left + $urandom_range(1, 300);
      if ($urandom_range(0, 4) == 0 || right > 4096) right = $urandom_range(1, 4096);
      program_regs(left, $urandom_range(0, 4095), right, $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 1));
    end
    quiet = (p % 4 == 3);
    accept_item(ActNewPicture, 8'($urandom));
    sender_gap();
    pause_at = $urandom_range(10, PhaseBytes - 10);
    sent     = 0;
    while (sent < PhaseBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        accept_item(ActNewPicture, 8'($urandom));
      end else begin
        b = (pick < 11) ? 8'($urandom) : next_stream_byte();
        accept_item(ActData, b);
        sent++;
      end
      queue_item_runs();
      sender_gap();
      if (sent == pause_at && pick >= 3) hold_until_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table: reset settings (right edge 720, index = code, contrast 0).
  // Typed rows are read straight off the decode rules.
  // --------------------------------------------------------------------------
  function automatic void add_row(input action_e a, input logic [7:0] d, input int n,
                                  input result_t r0 = '0, input result_t r1 = '0,
                                  input bit drain = 1'b0);
    dir_row_t row;
    row.act         = a;
    row.data        = d;
    row.n_typed     = n;
    row.run0        = r0;
    row.run1        = r1;
    row.drain_after = drain;
    dir_tab.push_back(row);
  endfunction

  function automatic void build_table();
    add_row(ActNewPicture, 8'hFF, 0);                                   // byte ignored
    add_row(ActData, 8'hFF, 2, mk_run(0, 0, 3, 3, 0, 0, 0), mk_run(3, 0, 3, 3, 0, 0, 0));
    add_row(ActData, 8'h00, 0);                                         // two nibbles held
    add_row(ActData, 8'h00, 1, mk_run(6, 0, 714, 0, 0, 1, 1), '0, 1'b1); // fill to edge
    add_row(ActNewPicture, 8'h5A, 0);
    add_row(ActData, 8'h40, Predicted);
    add_row(ActData, 8'h00, Predicted);
    add_row(ActData, 8'h0A, Predicted);   // fill on the high nibble, low one dropped
    add_row(ActData, 8'h13, Predicted);   // two-nibble code
    add_row(ActData, 8'h04, Predicted);   // three-nibble code
    add_row(ActData, 8'h7F, Predicted);
    add_row(ActData, 8'h03, Predicted);   // longest codes until the edge cuts one
    add_row(ActData, 8'hFF, Predicted);
    add_row(ActData, 8'h03, Predicted);
    add_row(ActData, 8'hFF, Predicted);
    add_row(ActData, 8'h03, Predicted);
    add_row(ActData, 8'hFF, Predicted);
    add_row(ActData, 8'h2C, Predicted);
    add_row(ActData, 8'hC8, Predicted);
    add_row(ActData, 8'h01, Predicted);
    add_row(ActData, 8'h80, Predicted);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: check on every accepting edge, then pick the next stall value.
  // Signals are sampled right after the edge, so they hold pre-edge values.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_run();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        stall_left = pick_stall() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    build_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      accept_item(dir_tab[i].act, dir_tab[i].data);
      if (dir_tab[i].n_typed == Predicted) begin
        queue_item_runs();
      end else begin
        if (dir_tab[i].n_typed > 0) pending_runs.push_back(dir_tab[i].run0);
        if (dir_tab[i].n_typed > 1) pending_runs.push_back(dir_tab[i].run1);
      end
      sender_gap();
      if (dir_tab[i].drain_after) hold_until_drained();
    end

    for (int p = 0; p < NumPhases; p++) run_phase(p);

    wait_drained();
    if (mismatch_count == 0 && pending_runs.size() == 0) begin
      $display("subpicture_rle_nibble_decoder_top_tb: PASS");
    end else begin
      $display("subpicture_rle_nibble_decoder_top_tb: FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #TimeoutNs;
    $display("subpicture_rle_nibble_decoder_top_tb: FAIL");
    $finish;
  end

endmodule
